// ===== hw/rtl/udp_port_bind_table_defines.svh =====
// assertion macros shared by the port binding table
`ifndef UDP_PORT_BIND_TABLE_DEFINES_SVH
`define UDP_PORT_BIND_TABLE_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define UPBT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udp_port_bind_table: check failed");

// consequence must hold in the cycle after the antecedent
`define UPBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udp_port_bind_table: check failed");

`endif

// ===== hw/rtl/upbt_pkg.sv =====
package upbt_pkg;

  // operation codes
  localparam logic [1:0] OP_OPEN     = 2'd0;
  localparam logic [1:0] OP_CLOSE    = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RESERVED  = 3'd1;
  localparam logic [2:0] ST_NO_FREE   = 3'd2;
  localparam logic [2:0] ST_BOUND     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_BOUND = 3'd5;

  // delivery codes
  localparam logic [1:0] DL_DHCP    = 2'd0;
  localparam logic [1:0] DL_LOCAL   = 2'd1;
  localparam logic [1:0] DL_UNREACH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_RESERVED_PORT   = 2'd0;
  localparam logic [1:0] CFG_EPHEMERAL_FIRST = 2'd1;
  localparam logic [1:0] CFG_EPHEMERAL_LAST  = 2'd2;

  // configuration reset values
  localparam int unsigned EPHEMERAL_END = 61000;
  localparam logic [15:0] RESERVED_PORT_RST   = 16'd68;
  localparam logic [15:0] EPHEMERAL_FIRST_RST = 16'd32768;
  localparam logic [15:0] EPHEMERAL_LAST_RST  = 16'(EPHEMERAL_END - 1);

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] port;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] port_out;
    logic [1:0]  delivery;
  } out_t;

  typedef struct packed {
    logic [15:0] reserved_port;
    logic [15:0] ephemeral_first;
    logic [15:0] ephemeral_last;
  } cfg_t;

  typedef enum logic [1:0] {
    K_OPEN,
    K_CLOSE,
    K_CLASSIFY
  } kind_t;

  // decoded command passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        reserved;
    logic        is_auto;
    logic [15:0] port;
  } cmd_t;

endpackage

// ===== hw/rtl/upbt_fifo.sv =====
module upbt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  upbt_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output upbt_pkg::cmd_t rd_data
);

  upbt_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/upbt_front.sv =====
module upbt_front (
  input  upbt_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  upbt_pkg::in_t   in_data,
  input  logic            full,
  output logic            push,
  output upbt_pkg::cmd_t  cmd
);

  assign in_ready = !full;
  assign push     = in_valid && !full;

  // decode the request into a command
  always_comb begin
    cmd.port     = in_data.port;
    cmd.reserved = (in_data.port == cfg.reserved_port);
    unique case (in_data.operation)
      upbt_pkg::OP_OPEN:  cmd.kind = upbt_pkg::K_OPEN;
      upbt_pkg::OP_CLOSE: cmd.kind = upbt_pkg::K_CLOSE;
      default:            cmd.kind = upbt_pkg::K_CLASSIFY;
    endcase
    // open of port zero that is not the reserved port picks a port
    cmd.is_auto = (in_data.operation == upbt_pkg::OP_OPEN) && !cmd.reserved &&
                  (in_data.port == 16'd0);
  end

endmodule

// ===== hw/rtl/upbt_back.sv =====
module upbt_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  upbt_pkg::cfg_t  cfg,
  input  logic            rd_valid,
  input  upbt_pkg::cmd_t  rd_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output upbt_pkg::out_t  out_data
);

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [2:0] {
    S_LOOK   = 3'b001,
    S_PICK   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                   state;
  logic [15:0]              bound_ports [TABLE_ENTRIES];
  upbt_pkg::cmd_t           cur;
  logic [16:0]              cand;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] empty_vec;

  logic [15:0]              key;
  logic [TABLE_ENTRIES-1:0] hit_next;
  logic [TABLE_ENTRIES-1:0] empty_next;
  logic [IDXW-1:0]          hit_idx;
  logic [IDXW-1:0]          empty_idx;
  logic                     any_hit;
  logic                     any_empty;
  logic                     load_ok;
  logic                     go_pick;
  logic                     wr_en;
  logic [IDXW-1:0]          wr_idx;
  logic [15:0]              wr_val;
  logic [15:0]              open_port;
  upbt_pkg::out_t           res;

  // compare the lookup key against every slot
  assign key = (state == S_PICK) ? cand[15:0] : rd_data.port;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_next[i]   = (bound_ports[i] == key) && (key != 16'd0);
      empty_next[i] = (bound_ports[i] == 16'd0);
    end
  end

  // lowest matching and lowest free slot from the registered vectors
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDXW'(i);
      end
      if (empty_vec[i]) begin
        empty_idx = IDXW'(i);
      end
    end
  end

  assign any_hit   = |hit_vec;
  assign any_empty = |empty_vec;
  assign load_ok   = !out_valid || out_ready;
  assign pop       = (state == S_LOOK) && rd_valid;
  assign open_port = cur.is_auto ? cand[15:0] : cur.port;

  // decide the result of the current command
  always_comb begin
    res          = '0;
    res.status   = upbt_pkg::ST_OK;
    res.delivery = upbt_pkg::DL_DHCP;
    res.port_out = cur.port;
    go_pick      = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = empty_idx;
    wr_val       = open_port;
    unique case (cur.kind)
      upbt_pkg::K_OPEN: begin
        if (cur.reserved) begin
          res.status = upbt_pkg::ST_RESERVED;
        end else if (cur.is_auto && (cand > {1'b0, cfg.ephemeral_last})) begin
          res.status   = upbt_pkg::ST_NO_FREE;
          res.port_out = 16'd0;
        end else if (cur.is_auto && ((cand[15:0] == 16'd0) || any_hit)) begin
          go_pick = 1'b1;
        end else begin
          res.port_out = open_port;
          if (any_hit) begin
            res.status = upbt_pkg::ST_BOUND;
          end else if (!any_empty) begin
            res.status = upbt_pkg::ST_FULL;
          end else begin
            wr_en    = 1'b1;
            res.slot = 4'(empty_idx);
          end
        end
      end
      upbt_pkg::K_CLOSE: begin
        if (any_hit) begin
          wr_en    = 1'b1;
          wr_idx   = hit_idx;
          wr_val   = 16'd0;
          res.slot = 4'(hit_idx);
        end else begin
          res.status = upbt_pkg::ST_NOT_BOUND;
        end
      end
      default: begin
        if (cur.reserved) begin
          res.delivery = upbt_pkg::DL_DHCP;
        end else if (any_hit) begin
          res.delivery = upbt_pkg::DL_LOCAL;
          res.slot     = 4'(hit_idx);
        end else begin
          res.delivery = upbt_pkg::DL_UNREACH;
        end
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOOK;
    end else begin
      unique case (state)
        S_LOOK: begin
          if (rd_valid) begin
            state <= rd_data.is_auto ? S_PICK : S_DECIDE;
          end
        end
        S_PICK: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (go_pick) begin
            state <= S_PICK;
          end else if (load_ok) begin
            state <= S_LOOK;
          end
        end
        default: begin
          state <= S_LOOK;
        end
      endcase
    end
  end

  // command, candidate and match vectors
  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= rd_data;
      cand <= {1'b0, cfg.ephemeral_first};
    end else if ((state == S_DECIDE) && go_pick) begin
      cand <= cand + 17'd1;
    end
    if (pop || (state == S_PICK)) begin
      hit_vec   <= hit_next;
      empty_vec <= empty_next;
    end
  end

  // binding table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        bound_ports[i] <= 16'd0;
      end
    end else if ((state == S_DECIDE) && !go_pick && load_ok && wr_en) begin
      bound_ports[wr_idx] <= wr_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DECIDE) && !go_pick && load_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DECIDE) && !go_pick && load_ok) begin
      out_data <= res;
    end
  end

endmodule

// ===== hw/rtl/udp_port_bind_table.sv =====
// the back-end sequencer runs look-up and decide steps for each transaction and registers the
// result at decide; an automatic open adds a pick step before deciding and another for each
// candidate port it skips (at most TABLE_ENTRIES+1); look-up and pick share one slot compare
// array; the next pop waits for the result; a 2-entry command queue buffers input
// reset: synchronous; all table slots become free, config registers take default values
`include "udp_port_bind_table_defines.svh"

module udp_port_bind_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  upbt_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output upbt_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  upbt_pkg::cfg_t cfg;
  upbt_pkg::cmd_t push_cmd;
  upbt_pkg::cmd_t head_cmd;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  logic [2:0]     inflight;
  logic           classified;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reserved_port   <= upbt_pkg::RESERVED_PORT_RST;
      cfg.ephemeral_first <= upbt_pkg::EPHEMERAL_FIRST_RST;
      cfg.ephemeral_last  <= upbt_pkg::EPHEMERAL_LAST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        upbt_pkg::CFG_RESERVED_PORT:   cfg.reserved_port   <= cfg_data;
        upbt_pkg::CFG_EPHEMERAL_FIRST: cfg.ephemeral_first <= cfg_data;
        upbt_pkg::CFG_EPHEMERAL_LAST:  cfg.ephemeral_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  upbt_front u_front (
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .cmd      (push_cmd)
  );

  upbt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (push_cmd),
    .full     (full),
    .pop      (pop),
    .rd_valid (head_valid),
    .rd_data  (head_cmd)
  );

  upbt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rd_valid  (head_valid),
    .rd_data   (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      inflight <= inflight + 3'd1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      inflight <= inflight - 3'd1;
    end
  end

  // result of a classify that is delivered locally or is unreachable
  assign classified = out_valid && (out_data.delivery != upbt_pkg::DL_DHCP);

  // checks
  `UPBT_ASSERT_NOW(a_no_result_after_reset, $past(rst), !out_valid)
  `UPBT_ASSERT_NOW(a_result_has_request, out_valid, inflight != 3'd0)
  `UPBT_ASSERT_NOW(a_classify_status_ok, classified, out_data.status == upbt_pkg::ST_OK)

endmodule
